### rtl/ray_disk_hit_test_macros.svh
// Assertion macros used by the checker file
`ifndef RAY_DISK_HIT_TEST_MACROS_SVH
`define RAY_DISK_HIT_TEST_MACROS_SVH
// Check that an implication holds on every rising clock edge outside reset
`define RDH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check a signal that must never be unknown outside reset
`define RDH_KNOWN(label, clk, rst_n, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
    else $error("signal unknown");
`endif

### rtl/rdh_pkg.sv
`timescale 1ns / 1ps
package rdh_pkg;
  localparam logic [34:0] OffClamp = 35'h4_0000_0000;
  localparam logic [66:0] ParLsb = 67'd4;

  localparam logic [2:0] RegCx = 3'd0;
  localparam logic [2:0] RegCy = 3'd1;
  localparam logic [2:0] RegCz = 3'd2;
  localparam logic [2:0] RegNx = 3'd3;
  localparam logic [2:0] RegNy = 3'd4;
  localparam logic [2:0] RegNz = 3'd5;
  localparam logic [2:0] RegRad = 3'd6;
  localparam logic [2:0] RegVis = 3'd7;
endpackage

### rtl/rdh_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: magnitude of dir*num by |den|, eight quotient
// bits per stage over eight stages, quotient saturated to the clamp.
module rdh_div (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [127:0] prod_i,
  input  logic [66:0]  den_i,
  output logic [34:0]  quo_o
);
  localparam int unsigned Stg = 8;
  logic [63:0]  rem_q [Stg+1];
  logic [63:0]  lo_q  [Stg+1];
  logic [63:0]  quo_q [Stg+1];
  logic [66:0]  den_q [Stg+1];
  logic         sat_q [Stg+1];

  // Load the high half as remainder, flag overflow up front
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= prod_i[127:64];
      lo_q[0]  <= prod_i[63:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      sat_q[0] <= ({3'b000, prod_i[127:64]} >= den_i);
    end
  end

  for (genvar s = 0; s < Stg; s++) begin : g_stg
    logic [64:0] r;
    logic [63:0] qq, ll;
    always_comb begin
      r  = {1'b0, rem_q[s]};
      qq = quo_q[s];
      ll = lo_q[s];
      for (int b = 0; b < 8; b++) begin
        r  = {r[63:0], ll[63]};
        ll = {ll[62:0], 1'b0};
        qq = {qq[62:0], 1'b0};
        if ({2'b00, r} >= den_q[s]) begin
          r = 65'(({2'b00, r} - den_q[s]));
          qq[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= r[63:0];
        lo_q[s+1]  <= ll;
        quo_q[s+1] <= qq;
        den_q[s+1] <= den_q[s];
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  // Saturate to the clamp
  assign quo_o = (sat_q[Stg] || quo_q[Stg] > 64'(rdh_pkg::OffClamp))
                 ? rdh_pkg::OffClamp : quo_q[Stg][34:0];
endmodule

### rtl/ray_disk_hit_test.sv
`timescale 1ns / 1ps
// Channel | direction | fields
// ray     | in        | origin_x/y/z, dir_x/y/z (valid_i, ready_o)
// result  | out       | hit, length_valid, hit_distance (valid_o, ready_i)
// config  | in        | APB registers 0..7 at byte address 4*i
// One word per cycle while the output is not stalled.
// The nine divider stages and the four square-root stages set the depth.
// Asynchronous active-low reset clears valid bits and sets config registers to defaults.
// A stall at the output freezes the whole pipeline; nothing is dropped.
module ray_disk_hit_test (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [31:0]  origin_x_i,
  input  logic signed [31:0]  origin_y_i,
  input  logic signed [31:0]  origin_z_i,
  input  logic signed [31:0]  dir_x_i,
  input  logic signed [31:0]  dir_y_i,
  input  logic signed [31:0]  dir_z_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic                hit_o,
  output logic                length_valid_o,
  output logic [31:0]         hit_distance_o
);
  localparam int unsigned Depth = 19;

  logic signed [31:0] cx_q, cy_q, cz_q;
  logic signed [17:0] nx_q, ny_q, nz_q;
  logic [30:0]        rad_q;
  logic               vis_q;
  logic [2:0]         ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; cz_q <= '0;
      nx_q <= '0; ny_q <= '0; nz_q <= 18'sd65536;
      rad_q <= 31'd65536; vis_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        rdh_pkg::RegCx:  cx_q <= pwdata;
        rdh_pkg::RegCy:  cy_q <= pwdata;
        rdh_pkg::RegCz:  cz_q <= pwdata;
        rdh_pkg::RegNx:  nx_q <= pwdata[17:0];
        rdh_pkg::RegNy:  ny_q <= pwdata[17:0];
        rdh_pkg::RegNz:  nz_q <= pwdata[17:0];
        rdh_pkg::RegRad: rad_q <= pwdata[30:0];
        rdh_pkg::RegVis: vis_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (ridx)
      rdh_pkg::RegCx:  prdata = cx_q;
      rdh_pkg::RegCy:  prdata = cy_q;
      rdh_pkg::RegCz:  prdata = cz_q;
      rdh_pkg::RegNx:  prdata = {{14{nx_q[17]}}, nx_q};
      rdh_pkg::RegNy:  prdata = {{14{ny_q[17]}}, ny_q};
      rdh_pkg::RegNz:  prdata = {{14{nz_q[17]}}, nz_q};
      rdh_pkg::RegRad: prdata = {1'b0, rad_q};
      rdh_pkg::RegVis: prdata = {31'd0, vis_q};
      default:         prdata = '0;
    endcase
  end

  // Global enable: advance when the output slot is free
  logic en;
  logic [Depth-1:0] vld_q;
  assign en = !valid_o || ready_i;
  assign ready_o = en;
  assign valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], valid_i};
  end

  // Stage 1: offsets d = c - o, register direction
  logic signed [32:0] d1_q [3];
  logic signed [31:0] r1_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= 33'(cx_q) - 33'(origin_x_i);
      d1_q[1] <= 33'(cy_q) - 33'(origin_y_i);
      d1_q[2] <= 33'(cz_q) - 33'(origin_z_i);
      r1_q[0] <= dir_x_i; r1_q[1] <= dir_y_i; r1_q[2] <= dir_z_i;
    end
  end

  // Stage 2: products
  logic signed [64:0] pa2_q [3];
  logic signed [50:0] pn2_q [3];
  logic signed [49:0] pd2_q [3];
  logic signed [32:0] d2_q [3];
  logic signed [31:0] r2_q [3];
  logic signed [17:0] nv [3];
  assign nv[0] = nx_q; assign nv[1] = ny_q; assign nv[2] = nz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa2_q[i] <= 65'(r1_q[i]) * 65'(d1_q[i]);
        pn2_q[i] <= 51'(nv[i]) * 51'(d1_q[i]);
        pd2_q[i] <= 50'(nv[i]) * 50'(r1_q[i]);
        d2_q[i] <= d1_q[i]; r2_q[i] <= r1_q[i];
      end
    end
  end

  // Stage 3: sums, miss tests
  logic signed [66:0] away3;
  logic signed [52:0] num3_q, den3_q;
  logic lv3_q;
  logic signed [32:0] d3_q [3];
  logic signed [31:0] r3_q [3];
  logic signed [52:0] den3;
  logic [52:0] dmag3;
  always_comb begin
    away3 = 67'(pa2_q[0]) + 67'(pa2_q[1]) + 67'(pa2_q[2]);
    den3 = 53'(pd2_q[0]) + 53'(pd2_q[1]) + 53'(pd2_q[2]);
    dmag3 = den3[52] ? 53'(-den3) : den3;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      num3_q <= 53'(pn2_q[0]) + 53'(pn2_q[1]) + 53'(pn2_q[2]);
      den3_q <= den3;
      lv3_q <= vis_q && !away3[66] && (67'(dmag3) > rdh_pkg::ParLsb);
      d3_q <= d2_q; r3_q <= r2_q;
    end
  end

  // Stage 4: |dir| * |num| per lane as two partial products
  logic [58:0]  pl4_q [3];
  logic [57:0]  ph4_q [3];
  logic [66:0]  dn4_q;
  logic         ng4_q [3];
  logic lv4_q;
  logic signed [32:0] d4_q [3];
  logic [52:0] nm4, dm4;
  logic [31:0] rm4 [3];
  always_comb begin
    nm4 = num3_q[52] ? 53'(-num3_q) : num3_q;
    dm4 = den3_q[52] ? 53'(-den3_q) : den3_q;
    for (int i = 0; i < 3; i++) rm4[i] = r3_q[i][31] ? 32'(-r3_q[i]) : r3_q[i];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl4_q[i] <= 59'(rm4[i]) * 59'(nm4[26:0]);
        ph4_q[i] <= 58'(rm4[i]) * 58'(nm4[52:27]);
        ng4_q[i] <= (r3_q[i][31] ^ num3_q[52] ^ den3_q[52]);
      end
      dn4_q <= 67'(dm4);
      lv4_q <= lv3_q;
      d4_q <= d3_q;
    end
  end

  // Join the partial products ahead of the divider load stage
  logic [127:0] pr4 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) pr4[i] = (128'(ph4_q[i]) << 27) + 128'(pl4_q[i]);
  end

  // Stages 5..13: divider lanes; side data delayed alongside
  logic [34:0] q12 [3];
  for (genvar l = 0; l < 3; l++) begin : g_div
    rdh_div u_div (.clk_i(clk_i), .en_i(en), .prod_i(pr4[l]), .den_i(dn4_q),
                   .quo_o(q12[l]));
  end
  localparam int unsigned DivD = 9;
  logic ng_dl [DivD][3];
  logic signed [32:0] d_dl [DivD][3];
  logic lv_dl [DivD];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ng_dl[0] <= ng4_q; d_dl[0] <= d4_q; lv_dl[0] <= lv4_q;
      for (int k = 1; k < DivD; k++) begin
        ng_dl[k] <= ng_dl[k-1]; d_dl[k] <= d_dl[k-1]; lv_dl[k] <= lv_dl[k-1];
      end
    end
  end

  // Stage 14: signed offsets, squares of v and of v - d
  logic [63:0] sq14_q [3];
  logic [63:0] e14_q [3];
  logic        eb14_q, big14_q, lv14_q;
  logic signed [35:0] v14 [3];
  logic signed [36:0] e14 [3];
  logic [36:0] em14 [3];
  logic        eb14, big14;
  always_comb begin
    eb14 = 1'b0;
    big14 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v14[i] = ng_dl[DivD-1][i] ? -36'(q12[i]) : 36'(q12[i]);
      e14[i] = 37'(v14[i]) - 37'(d_dl[DivD-1][i]);
      em14[i] = e14[i][36] ? 37'(-e14[i]) : e14[i];
      if (em14[i] >= 37'h0_8000_0000) eb14 = 1'b1;
      if (q12[i] >= 35'h1_0000_0000) big14 = 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      eb14_q <= eb14; big14_q <= big14;
      for (int i = 0; i < 3; i++) begin
        sq14_q[i] <= 64'(q12[i][31:0]) * 64'(q12[i][31:0]);
        e14_q[i] <= 64'(em14[i][30:0]) * 64'(em14[i][30:0]);
      end
      lv14_q <= lv_dl[DivD-1];
    end
  end

  // Stage 15: sum squares, radius test
  logic [65:0] acc15;
  logic [63:0] acc15_q;
  logic ov15_q, in15_q, lv15_q;
  logic [63:0] e2;
  always_comb begin
    acc15 = 66'(sq14_q[0]) + 66'(sq14_q[1]) + 66'(sq14_q[2]);
    e2 = e14_q[0] + e14_q[1] + e14_q[2];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      acc15_q <= acc15[63:0];
      ov15_q <= big14_q || (acc15[65:64] != 2'b00);
      in15_q <= !eb14_q && (e2 < 64'(rad_q) * 64'(rad_q));
      lv15_q <= lv14_q;
    end
  end

  // Stages 16..19: square root, 8 result bits per stage
  localparam int unsigned SqSt = 4;
  logic [63:0] sx_q [1:SqSt];
  logic [34:0] sm_q [1:SqSt];
  logic [31:0] sr_q [1:SqSt];
  logic sv_q [1:SqSt], si_q [1:SqSt], so_q [1:SqSt];
  for (genvar s = 0; s < SqSt; s++) begin : g_sqrt
    logic [63:0] x_in, x;
    logic [34:0] m_in, m;
    logic [31:0] r_in, r;
    logic [33:0] t;
    logic v_in, i_in, o_in;
    if (s == 0) begin : g_head
      assign x_in = acc15_q; assign m_in = '0; assign r_in = '0;
      assign v_in = lv15_q; assign i_in = in15_q; assign o_in = ov15_q;
    end else begin : g_tail
      assign x_in = sx_q[s]; assign m_in = sm_q[s]; assign r_in = sr_q[s];
      assign v_in = sv_q[s]; assign i_in = si_q[s]; assign o_in = so_q[s];
    end
    always_comb begin
      x = x_in;
      m = m_in;
      r = r_in;
      t = '0;
      for (int b = 0; b < 8; b++) begin
        m = {m[32:0], x[63:62]};
        x = {x[61:0], 2'b00};
        t = {r, 2'b01};
        if (m >= 35'(t)) begin
          m = m - 35'(t);
          r = {r[30:0], 1'b1};
        end else begin
          r = {r[30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sx_q[s+1] <= x; sm_q[s+1] <= m; sr_q[s+1] <= r;
        sv_q[s+1] <= v_in; si_q[s+1] <= i_in; so_q[s+1] <= o_in;
      end
    end
  end

  assign hit_o = sv_q[SqSt] && si_q[SqSt];
  assign length_valid_o = sv_q[SqSt];
  assign hit_distance_o = !sv_q[SqSt] ? 32'd0 :
                          (so_q[SqSt] ? 32'hFFFF_FFFF : sr_q[SqSt]);
endmodule

### rtl/rdh_checker.sv
`timescale 1ns / 1ps
`include "ray_disk_hit_test_macros.svh"
module rdh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        ready_i,
  input logic        hit_o,
  input logic        length_valid_o,
  input logic [31:0] hit_distance_o
);
  `RDH_ASSERT(a_hit_len, clk_i, rst_ni, valid_o && hit_o |-> length_valid_o)
  `RDH_ASSERT(a_miss_zero, clk_i, rst_ni, valid_o && !length_valid_o |-> hit_distance_o == 32'd0)
  `RDH_ASSERT(a_hold, clk_i, rst_ni, valid_o && !ready_i |=> valid_o && $stable(hit_distance_o))
  `RDH_KNOWN(a_known, clk_i, rst_ni, valid_o)
endmodule

bind ray_disk_hit_test rdh_checker u_rdh_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_o(valid_o), .ready_i(ready_i),
  .hit_o(hit_o), .length_valid_o(length_valid_o), .hit_distance_o(hit_distance_o)
);

### tb/ray_disk_hit_test_test.sv
`timescale 1ns / 1ps
module ray_disk_hit_test_test;

  localparam int unsigned Q = 65536;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned ItemsPerSetting = 165;
  localparam int unsigned NumSettings = 7;

  typedef struct {
    bit        hit;
    bit        length_valid;
    bit [31:0] distance;
  } disk_result_t;

  // Predicts the disc test and holds the results still owed by the block
  class disk_scoreboard;
    logic signed [31:0] cx, cy, cz;
    logic signed [17:0] nx, ny, nz;
    logic [30:0]        rad;
    bit                 vis;
    disk_result_t       owed[$];
    int                 errors;
    int                 rays, hits, lengths;

    function new();
      cx = 0; cy = 0; cz = 0;
      nx = 0; ny = 0; nz = 18'sd65536;
      rad = 31'd65536;
      vis = 1'b1;
      errors = 0; rays = 0; hits = 0; lengths = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        rdh_pkg::RegCx: cx = val;
        rdh_pkg::RegCy: cy = val;
        rdh_pkg::RegCz: cz = val;
        rdh_pkg::RegNx: nx = val[17:0];
        rdh_pkg::RegNy: ny = val[17:0];
        rdh_pkg::RegNz: nz = val[17:0];
        rdh_pkg::RegRad: rad = val[30:0];
        rdh_pkg::RegVis: vis = val[0];
        default: ;
      endcase
    endfunction

    function bit [63:0] mag(longint a);
      return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    // dir * num / den toward zero, magnitude clamped
    function longint offset(longint dir, longint num, longint den);
      logic [127:0] p, q;
      bit neg;
      p = 128'(mag(dir)) * 128'(mag(num));
      q = p / 128'(mag(den));
      if (q > 128'(rdh_pkg::OffClamp)) q = 128'(rdh_pkg::OffClamp);
      neg = (dir < 0) ^ (num < 0) ^ (den < 0);
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function bit [63:0] root_floor(bit [63:0] x);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function disk_result_t trace(logic signed [31:0] ray[6]);
      longint c[3], nv[3], o[3], dr[3], d[3], v[3];
      logic signed [127:0] s, a, b;
      longint num, den;
      bit big, in_disc;
      logic [65:0] acc;
      bit [63:0] e, e2;
      disk_result_t r;
      r = '{hit: 1'b0, length_valid: 1'b0, distance: 32'd0};
      c[0] = cx; c[1] = cy; c[2] = cz;
      nv[0] = nx; nv[1] = ny; nv[2] = nz;
      for (int i = 0; i < 3; i++) begin
        o[i] = ray[i];
        dr[i] = ray[3 + i];
        d[i] = c[i] - o[i];
      end
      if (!vis) return r;
      // away test on the exact dot product
      s = 0;
      for (int i = 0; i < 3; i++) begin
        a = dr[i];
        b = d[i];
        s = s + a * b;
      end
      if (s < 0) return r;
      num = 0;
      den = 0;
      for (int i = 0; i < 3; i++) begin
        num = num + nv[i] * d[i];
        den = den + nv[i] * dr[i];
      end
      if (mag(den) <= 64'(rdh_pkg::ParLsb)) return r;
      big = 1'b0;
      for (int i = 0; i < 3; i++) begin
        v[i] = offset(dr[i], num, den);
        if (mag(v[i]) >= 64'h1_0000_0000) big = 1'b1;
      end
      r.length_valid = 1'b1;
      r.distance = '1;
      if (!big) begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc = acc + 66'(mag(v[i]) * mag(v[i]));
        if (acc[65:64] == 2'b00) r.distance = root_floor(acc[63:0]);
      end
      // strict inside test on squared distances
      in_disc = 1'b1;
      e2 = 0;
      for (int i = 0; i < 3; i++) begin
        e = mag(v[i] - d[i]);
        if (e >= 64'h8000_0000) in_disc = 1'b0;
        else e2 = e2 + e * e;
      end
      if (in_disc) in_disc = e2 < 64'(rad) * 64'(rad);
      r.hit = in_disc;
      return r;
    endfunction

    function void note_ray(logic signed [31:0] ray[6]);
      disk_result_t r;
      r = trace(ray);
      rays++;
      if (r.hit) hits++;
      if (r.length_valid) lengths++;
      owed.insert(owed.size(), r);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(bit hit, bit lv, bit [31:0] distance);
      disk_result_t x;
      if (owed.size() == 0) begin
        report("result word with nothing pending");
        return;
      end
      x = owed.pop_front();
      if (hit !== x.hit) report($sformatf("hit %0b, want %0b", hit, x.hit));
      if (lv !== x.length_valid)
        report($sformatf("length_valid %0b, want %0b", lv, x.length_valid));
      if (distance !== x.distance)
        report($sformatf("hit_distance %h, want %h", distance, x.distance));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic valid_i = 1'b0;
  logic ready_o;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic hit_o, length_valid_o;
  logic [31:0] hit_distance_o;

  disk_scoreboard sb = new();
  int send_idle = 23;
  int recv_stall = 74;
  int quiet = 0;

  ray_disk_hit_test uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sample both channels before this edge's updates land
  always @(posedge clk_i) begin
    logic signed [31:0] ray[6];
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      ready_i <= ($urandom_range(0, 99) >= recv_stall);
      if (valid_i && ready_o) begin
        ray = '{origin_x_i, origin_y_i, origin_z_i, dir_x_i, dir_y_i, dir_z_i};
        sb.note_ray(ray);
        moved = 1'b1;
      end
      if (valid_o && ready_i) begin
        sb.check_result(hit_o, length_valid_o, hit_distance_o);
        moved = 1'b1;
      end
      quiet <= moved ? 0 : quiet + 1;
      if (quiet >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task set_disk(logic [31:0] cx, cy, cz, nx, ny, nz, rad, vis);
    write_reg(rdh_pkg::RegCx, cx);
    write_reg(rdh_pkg::RegCy, cy);
    write_reg(rdh_pkg::RegCz, cz);
    write_reg(rdh_pkg::RegNx, nx);
    write_reg(rdh_pkg::RegNy, ny);
    write_reg(rdh_pkg::RegNz, nz);
    write_reg(rdh_pkg::RegRad, rad);
    write_reg(rdh_pkg::RegVis, vis);
  endtask

  // Hold the sender until every pending result is back
  task drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task send_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
    while ($urandom_range(0, 99) < send_idle) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    origin_x_i <= ox;
    origin_y_i <= oy;
    origin_z_i <= oz;
    dir_x_i <= dx;
    dir_y_i <= dy;
    dir_z_i <= dz;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
  endtask

  function logic signed [31:0] spread(int unsigned span);
    return $signed($urandom_range(0, 2 * span)) - $signed(span);
  endfunction

  function logic signed [31:0] corner();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function logic [31:0] any_normal();
    return 32'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  // Mostly rays aimed at the disc, some noise and corner values
  task random_ray();
    logic signed [31:0] o[3], t[3], dv[3];
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (mode < 2) begin
        o[i] = $urandom;
        dv[i] = $urandom;
      end else if (mode == 2) begin
        o[i] = corner();
        dv[i] = corner();
      end else begin
        t[i] = (i == 0 ? sb.cx : i == 1 ? sb.cy : sb.cz);
        o[i] = t[i] + spread(1 << 20);
        t[i] = t[i] + spread(1 << 18);
        dv[i] = (t[i] - o[i]) >>> $urandom_range(0, 4);
      end
    end
    send_ray(o[0], o[1], o[2], dv[0], dv[1], dv[2]);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset disc: unit circle in the z = 0 plane
    send_ray(0, 0, 5 * Q, 0, 0, -Q);
    send_ray(0, 0, 5 * Q, 0, 0, Q);
    send_ray(0, 0, 5 * Q, Q, 0, 0);
    send_ray(2 * Q, 0, 5 * Q, 0, 0, -Q);
    send_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_ray(0, 0, -3 * Q, Q / 2, 0, Q);
    send_ray(0, 0, Q, 0, 0, -1);
    send_ray(0, 0, 32'sh7fff_0000, 32'sh7fff_ffff, 0, -1);
    send_ray(0, 0, 0, Q, Q, Q);
    send_ray(Q / 2, Q / 2, Q, 0, 0, -Q);
    send_ray(Q - 1, 0, Q, 0, 0, -Q);
    send_ray(Q, 0, Q, 0, 0, -Q);
    drain();

    // Tiny normal: parallel threshold either side, zero radius
    set_disk(0, 0, 0, 0, 0, 1, 0, 1);
    send_ray(0, 0, Q, 0, 0, -4);
    send_ray(0, 0, Q, 0, 0, -5);
    send_ray(0, 0, Q, 0, 0, 4);
    drain();
    set_disk(0, 0, 0, 0, 0, Q, Q, 0);
    send_ray(0, 0, 5 * Q, 0, 0, -Q);
    drain();

    for (int ph = 0; ph < NumSettings; ph++) begin
      case (ph)
        0: set_disk(spread(16 * Q), spread(16 * Q), spread(16 * Q),
                    0, ($urandom_range(0, 1) ? Q : -Q), 0, $urandom_range(0, 8 * Q), 1);
        1: set_disk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    -Q, 0, 0, 32'h7fff_ffff, 1);
        2: set_disk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    0, Q, 0, 0, 1);
        3: set_disk($urandom, $urandom, $urandom, any_normal(), any_normal(),
                    any_normal(), $urandom, 0);
        default: set_disk(spread(16 * Q), spread(16 * Q), spread(16 * Q),
                          any_normal(), any_normal(), any_normal(),
                          $urandom_range(0, 16 * Q), 1);
      endcase
      if (ph == 2) begin
        send_idle = 74;
        recv_stall = 23;
      end else if (ph == 5) begin
        send_idle = 0;
        recv_stall = 0;
      end
      repeat (ItemsPerSetting) random_ray();
      drain();
    end

    $display("rays sent: %0d, with a plane point: %0d, inside the disc: %0d",
             sb.rays, sb.lengths, sb.hits);
    $display("covered reset, corner and random disc settings under both stall patterns");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
